[hdl/point_rotation_about_center_unit_macros.svh]
// Assertion macros shared by the point rotation RTL.
// Has no dependencies; included by the modules that carry assertions.
`ifndef POINT_ROTATION_ABOUT_CENTER_UNIT_MACROS_SVH
`define POINT_ROTATION_ABOUT_CENTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRAC_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRAC_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/prac_pkg.sv]
// Shared constants and the arctangent table for the point rotation pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package prac_pkg;

    localparam int GUARD_BITS = 8;
    localparam int MAX_STAGES = 24;
    localparam int ANGLE_W    = 16;
    localparam int ZW         = 33;
    localparam int ATAN_W     = 30;
    localparam int PROD_SHIFT = 32 - GUARD_BITS;

    localparam logic [31:0]             GAIN_K        = 32'd2608131496;
    localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 16'sd16384;
    localparam logic signed [ZW-1:0]    Z_LIMIT       = 33'sd1073741824;

    // atan(2^-i) in units of 2^-32 turn, truncated.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 30'h20000000;
                5'd1:    val = 30'h12E4051D;
                5'd2:    val = 30'h09FB385B;
                5'd3:    val = 30'h051111D4;
                5'd4:    val = 30'h028B0D43;
                5'd5:    val = 30'h0145D7E1;
                5'd6:    val = 30'h00A2F61E;
                5'd7:    val = 30'h00517C55;
                5'd8:    val = 30'h0028BE53;
                5'd9:    val = 30'h00145F2F;
                5'd10:   val = 30'h000A2F98;
                5'd11:   val = 30'h000517CC;
                5'd12:   val = 30'h00028BE6;
                5'd13:   val = 30'h000145F3;
                5'd14:   val = 30'h0000A2F9;
                5'd15:   val = 30'h0000517C;
                5'd16:   val = 30'h000028BE;
                5'd17:   val = 30'h0000145F;
                5'd18:   val = 30'h00000A2F;
                5'd19:   val = 30'h00000517;
                5'd20:   val = 30'h0000028B;
                5'd21:   val = 30'h00000145;
                5'd22:   val = 30'h000000A2;
                5'd23:   val = 30'h00000051;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

[hdl/prac_prep.sv]
// Front end of the rotation pipeline: offset, gain compensation and folding.
// Depends on prac_pkg; five register stages with valid/ready per stage.
`timescale 1ns / 1ps

module prac_prep
    import prac_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int XW          = 43
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COORD_WIDTH-1:0]        pt_x,
    input  logic [COORD_WIDTH-1:0]        pt_y,
    input  logic [COORD_WIDTH-1:0]        pv_x,
    input  logic [COORD_WIDTH-1:0]        pv_y,
    input  logic signed [ANGLE_W-1:0]     ang,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic signed [ZW-1:0]          z_out,
    output logic [COORD_WIDTH-1:0]        cx_out,
    output logic [COORD_WIDTH-1:0]        cy_out
);

    localparam int MW = COORD_WIDTH + 1;
    localparam int EW = ((MW > 32) ? MW : 32) + 1;
    localparam int HW = EW - 32;
    localparam int PW = EW + 32;
    localparam int RW = PW - PROD_SHIFT;
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (PROD_SHIFT - 1);

    logic [4:0] valid_reg;
    logic [4:0] adv;

    // Stage A
    logic [MW-1:0]          rel_x_reg, rel_y_reg;
    logic                   fold_a_reg;
    logic [ANGLE_W-1:0]     ang_a_reg;
    logic [COORD_WIDTH-1:0] cx_a_reg, cy_a_reg;
    // Stage B
    logic [EW-1:0]          mag_x_reg, mag_y_reg;
    logic                   neg_x_b_reg, neg_y_b_reg, fold_b_reg;
    logic [ANGLE_W-1:0]     ang_b_reg;
    logic [COORD_WIDTH-1:0] cx_b_reg, cy_b_reg;
    // Stage C
    logic [63:0]            lo_x_reg, lo_y_reg;
    logic [HW+31:0]         hi_x_reg, hi_y_reg;
    logic                   neg_x_c_reg, neg_y_c_reg, fold_c_reg;
    logic [ANGLE_W-1:0]     ang_c_reg;
    logic [COORD_WIDTH-1:0] cx_c_reg, cy_c_reg;
    // Stage D
    logic [RW-1:0]          r_x_reg, r_y_reg;
    logic                   neg_x_d_reg, neg_y_d_reg, fold_d_reg;
    logic [ANGLE_W-1:0]     ang_d_reg;
    logic [COORD_WIDTH-1:0] cx_d_reg, cy_d_reg;
    // Stage E
    logic signed [XW-1:0]   x_e_reg, y_e_reg;
    logic signed [ZW-1:0]   z_e_reg;
    logic [COORD_WIDTH-1:0] cx_e_reg, cy_e_reg;

    logic [MW-1:0]          rel_x_next, rel_y_next;
    logic                   fold_next;
    logic [ANGLE_W-1:0]     ang_next;
    logic [MW-1:0]          abs_x, abs_y;
    logic [PW-1:0]          acc_x, acc_y;
    logic signed [XW-1:0]   sx, sy;
    logic                   flip_x, flip_y;

    always_comb
    begin
        adv[4] = !valid_reg[4] || out_ready;
        for (int k = 3; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < 5; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Fold the angle into the right half-plane; both directions flip the top bit.
    always_comb
    begin
        rel_x_next = {pt_x[COORD_WIDTH-1], pt_x} - {pv_x[COORD_WIDTH-1], pv_x};
        rel_y_next = {pt_y[COORD_WIDTH-1], pt_y} - {pv_y[COORD_WIDTH-1], pv_y};
        fold_next  = (ang > ANGLE_QUARTER) || (ang < -ANGLE_QUARTER);
        ang_next   = fold_next ? {~ang[ANGLE_W-1], ang[ANGLE_W-2:0]} : ang;
    end

    always_comb
    begin
        abs_x = rel_x_reg[MW-1] ? MW'(~rel_x_reg + 1'b1) : rel_x_reg;
        abs_y = rel_y_reg[MW-1] ? MW'(~rel_y_reg + 1'b1) : rel_y_reg;
    end

    // Magnitude times K, rounded half up off the product fraction.
    always_comb
    begin
        acc_x = {hi_x_reg, 32'b0} + PW'(lo_x_reg) + ROUND_HALF;
        acc_y = {hi_y_reg, 32'b0} + PW'(lo_y_reg) + ROUND_HALF;
    end

    always_comb
    begin
        flip_x = neg_x_d_reg ^ fold_d_reg;
        flip_y = neg_y_d_reg ^ fold_d_reg;
        sx     = $signed({{(XW-RW){1'b0}}, r_x_reg});
        sy     = $signed({{(XW-RW){1'b0}}, r_y_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rel_x_reg  <= rel_x_next;
            rel_y_reg  <= rel_y_next;
            fold_a_reg <= fold_next;
            ang_a_reg  <= ang_next;
            cx_a_reg   <= pv_x;
            cy_a_reg   <= pv_y;
        end
        if (adv[1])
        begin
            mag_x_reg   <= {{(EW-MW){1'b0}}, abs_x};
            mag_y_reg   <= {{(EW-MW){1'b0}}, abs_y};
            neg_x_b_reg <= rel_x_reg[MW-1];
            neg_y_b_reg <= rel_y_reg[MW-1];
            fold_b_reg  <= fold_a_reg;
            ang_b_reg   <= ang_a_reg;
            cx_b_reg    <= cx_a_reg;
            cy_b_reg    <= cy_a_reg;
        end
        if (adv[2])
        begin
            lo_x_reg    <= mag_x_reg[31:0] * GAIN_K;
            lo_y_reg    <= mag_y_reg[31:0] * GAIN_K;
            hi_x_reg    <= mag_x_reg[EW-1:32] * GAIN_K;
            hi_y_reg    <= mag_y_reg[EW-1:32] * GAIN_K;
            neg_x_c_reg <= neg_x_b_reg;
            neg_y_c_reg <= neg_y_b_reg;
            fold_c_reg  <= fold_b_reg;
            ang_c_reg   <= ang_b_reg;
            cx_c_reg    <= cx_b_reg;
            cy_c_reg    <= cy_b_reg;
        end
        if (adv[3])
        begin
            r_x_reg     <= acc_x[PW-1:PROD_SHIFT];
            r_y_reg     <= acc_y[PW-1:PROD_SHIFT];
            neg_x_d_reg <= neg_x_c_reg;
            neg_y_d_reg <= neg_y_c_reg;
            fold_d_reg  <= fold_c_reg;
            ang_d_reg   <= ang_c_reg;
            cx_d_reg    <= cx_c_reg;
            cy_d_reg    <= cy_c_reg;
        end
        if (adv[4])
        begin
            x_e_reg  <= flip_x ? -sx : sx;
            y_e_reg  <= flip_y ? -sy : sy;
            z_e_reg  <= $signed({{(ZW-ANGLE_W-16){ang_d_reg[ANGLE_W-1]}}, ang_d_reg, 16'b0});
            cx_e_reg <= cx_d_reg;
            cy_e_reg <= cy_d_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign x_out     = x_e_reg;
    assign y_out     = y_e_reg;
    assign z_out     = z_e_reg;
    assign cx_out    = cx_e_reg;
    assign cy_out    = cy_e_reg;

endmodule

[hdl/prac_cordic_stage.sv]
// One rotation-mode CORDIC iteration with its own pipeline register.
// Depends on prac_pkg for the arctangent table.
`timescale 1ns / 1ps

module prac_cordic_stage
    import prac_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int XW          = 43,
    parameter int STAGE       = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [XW-1:0]   x_in,
    input  logic signed [XW-1:0]   y_in,
    input  logic signed [ZW-1:0]   z_in,
    input  logic [COORD_WIDTH-1:0] cx_in,
    input  logic [COORD_WIDTH-1:0] cy_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [XW-1:0]   x_out,
    output logic signed [XW-1:0]   y_out,
    output logic signed [ZW-1:0]   z_out,
    output logic [COORD_WIDTH-1:0] cx_out,
    output logic [COORD_WIDTH-1:0] cy_out
);

    localparam logic signed [ZW-1:0] ATAN_STEP =
        $signed({{(ZW-ATAN_W){1'b0}}, atan_entry(5'(STAGE))});

    logic                   valid_reg;
    logic                   adv;
    logic signed [XW-1:0]   x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0]   z_reg;
    logic [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic                   ccw;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    assign xs  = x_in >>> STAGE;
    assign ys  = y_in >>> STAGE;
    assign ccw = !z_in[ZW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg  <= ccw ? (x_in - ys) : (x_in + ys);
            y_reg  <= ccw ? (y_in + xs) : (y_in - xs);
            z_reg  <= ccw ? (z_in - ATAN_STEP) : (z_in + ATAN_STEP);
            cx_reg <= cx_in;
            cy_reg <= cy_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign cx_out    = cx_reg;
    assign cy_out    = cy_reg;

endmodule

[hdl/prac_post.sv]
// Back end of the rotation pipeline: guard-bit rounding, pivot add, saturation.
// Depends on prac_pkg; its second stage is the output register of the block.
`timescale 1ns / 1ps

module prac_post
    import prac_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int XW          = 43
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [XW-1:0]   x_in,
    input  logic signed [XW-1:0]   y_in,
    input  logic [COORD_WIDTH-1:0] cx_in,
    input  logic [COORD_WIDTH-1:0] cy_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] rx_out,
    output logic [COORD_WIDTH-1:0] ry_out,
    output logic                   clip_out
);

    localparam int RXW = XW - GUARD_BITS;
    localparam int SW  = RXW + 1;
    localparam logic [XW-1:0] ROUND_OUT = XW'(1) << (GUARD_BITS - 1);
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [1:0]             valid_reg;
    logic [1:0]             adv;
    logic [RXW-1:0]         rnd_x_reg, rnd_y_reg;
    logic [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic [COORD_WIDTH-1:0] rx_reg, ry_reg;
    logic                   clip_reg;

    logic [XW-1:0]          tx, ty;
    logic [SW-1:0]          sum_x, sum_y;
    logic                   ovf_x, ovf_y;
    logic [COORD_WIDTH-1:0] sat_x, sat_y;

    assign adv[1]   = !valid_reg[1] || out_ready;
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    // Floor of (v + half) leaves the guard bits behind.
    assign tx = x_in + ROUND_OUT;
    assign ty = y_in + ROUND_OUT;

    always_comb
    begin
        sum_x = {rnd_x_reg[RXW-1], rnd_x_reg}
              + {{(SW-COORD_WIDTH){cx_reg[COORD_WIDTH-1]}}, cx_reg};
        sum_y = {rnd_y_reg[RXW-1], rnd_y_reg}
              + {{(SW-COORD_WIDTH){cy_reg[COORD_WIDTH-1]}}, cy_reg};
        ovf_x = !((&sum_x[SW-1:COORD_WIDTH-1]) || !(|sum_x[SW-1:COORD_WIDTH-1]));
        ovf_y = !((&sum_y[SW-1:COORD_WIDTH-1]) || !(|sum_y[SW-1:COORD_WIDTH-1]));
        sat_x = ovf_x ? (sum_x[SW-1] ? COORD_MIN : COORD_MAX) : sum_x[COORD_WIDTH-1:0];
        sat_y = ovf_y ? (sum_y[SW-1] ? COORD_MIN : COORD_MAX) : sum_y[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rnd_x_reg <= tx[XW-1:GUARD_BITS];
            rnd_y_reg <= ty[XW-1:GUARD_BITS];
            cx_reg    <= cx_in;
            cy_reg    <= cy_in;
        end
        if (adv[1])
        begin
            rx_reg   <= sat_x;
            ry_reg   <= sat_y;
            clip_reg <= ovf_x || ovf_y;
        end
    end

    assign out_valid = valid_reg[1];
    assign rx_out    = rx_reg;
    assign ry_out    = ry_reg;
    assign clip_out  = clip_reg;

endmodule

[hdl/point_rotation_about_center_unit.sv]
// Point rotation about a pivot: offset, gain compensation, CORDIC, pivot add.
// The pipeline has five front-end stages, one register per CORDIC iteration (stages above 24
// are not built) and two back-end stages.
// Throughput is one transaction per cycle; each stage stalls only when the stage after it is full.
// Reset (rst_n, asynchronous, active low) empties every stage; data registers are not cleared.
// Depends on prac_pkg, prac_prep, prac_cordic_stage, prac_post and the assertion macros.
`timescale 1ns / 1ps

`include "point_rotation_about_center_unit_macros.svh"

module point_rotation_about_center_unit
    import prac_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // point_x, point_y, pivot_x, pivot_y, turn_angle, zero fill to whole bytes
    input  logic [((4*COORD_WIDTH+ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // rotated_x, rotated_y, zero fill to whole bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // clipped
    output logic                m_axis_tuser
);

    // Number of CORDIC iterations actually built; the arctangent table stops at 24.
    localparam int NS = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

    // Datapath width. The gain-compensated offset keeps GUARD_BITS extra fraction
    // bits; two spare bits cover the sign and the CORDIC growth of about 1.65.
    localparam int MW     = COORD_WIDTH + 1;
    localparam int EW     = ((MW > 32) ? MW : 32) + 1;
    localparam int RW     = EW + 32 - PROD_SHIFT;
    localparam int XW     = RW + 2;
    localparam int OUT_TW = ((2*COORD_WIDTH+7)/8)*8;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Unpacked input fields of one transaction.
    logic [COORD_WIDTH-1:0]   point_x, point_y, pivot_x, pivot_y;
    logic signed [ANGLE_W-1:0] turn_angle;

    assign point_x    = s_axis_tdata[COORD_WIDTH-1:0];
    assign point_y    = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign pivot_x    = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign pivot_y    = s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
    assign turn_angle = $signed(s_axis_tdata[4*COORD_WIDTH+ANGLE_W-1:4*COORD_WIDTH]);

    // CORDIC chain. Index k is the input of iteration k; index NS feeds the back end.
    logic                   valid_c [0:NS];
    logic                   ready_c [0:NS];
    logic signed [XW-1:0]   x_c     [0:NS];
    logic signed [XW-1:0]   y_c     [0:NS];
    logic signed [ZW-1:0]   z_c     [0:NS];
    logic [COORD_WIDTH-1:0] cx_c    [0:NS];
    logic [COORD_WIDTH-1:0] cy_c    [0:NS];

    logic [COORD_WIDTH-1:0] rotated_x, rotated_y;
    logic                   clipped;

    // Front end: the offset from the pivot is scaled by the CORDIC gain
    // compensation and, for angles beyond a quarter turn, negated while the
    // angle is brought back by half a turn.
    prac_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pt_x      (point_x),
        .pt_y      (point_y),
        .pv_x      (pivot_x),
        .pv_y      (pivot_y),
        .ang       (turn_angle),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .x_out     (x_c[0]),
        .y_out     (y_c[0]),
        .z_out     (z_c[0]),
        .cx_out    (cx_c[0]),
        .cy_out    (cy_c[0])
    );

    // One registered iteration per stage; the pivot rides along with the vector.
    for (genvar g = 0; g < NS; g++)
    begin : g_cordic
        prac_cordic_stage #(
            .COORD_WIDTH (COORD_WIDTH),
            .XW          (XW),
            .STAGE       (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[g]),
            .in_ready  (ready_c[g]),
            .x_in      (x_c[g]),
            .y_in      (y_c[g]),
            .z_in      (z_c[g]),
            .cx_in     (cx_c[g]),
            .cy_in     (cy_c[g]),
            .out_valid (valid_c[g+1]),
            .out_ready (ready_c[g+1]),
            .x_out     (x_c[g+1]),
            .y_out     (y_c[g+1]),
            .z_out     (z_c[g+1]),
            .cx_out    (cx_c[g+1]),
            .cy_out    (cy_c[g+1])
        );
    end

    // Back end: rounding off the guard bits, pivot add and saturation. Its last
    // register is the output register, so a result waiting on m_axis_tready
    // does not stop earlier stages from filling.
    prac_post #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_c[NS]),
        .in_ready  (ready_c[NS]),
        .x_in      (x_c[NS]),
        .y_in      (y_c[NS]),
        .cx_in     (cx_c[NS]),
        .cy_in     (cy_c[NS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .rx_out    (rotated_x),
        .ry_out    (rotated_y),
        .clip_out  (clipped)
    );

    assign m_axis_tdata = OUT_TW'({rotated_y, rotated_x});
    assign m_axis_tuser = clipped;

    // After folding, the starting angle lies within a quarter turn either way.
    `PRAC_ASSERT_IMPL(a_fold_range, clk, rst_n, valid_c[0],
        (z_c[0] <= Z_LIMIT) && (z_c[0] >= -Z_LIMIT), "folded angle out of range")

    // A clipped result carries at least one coordinate at a range limit.
    `PRAC_ASSERT_IMPL(a_clip_limit, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        (rotated_x == COORD_MAX) || (rotated_x == COORD_MIN) ||
        (rotated_y == COORD_MAX) || (rotated_y == COORD_MIN), "clip flag without saturation")

    // The input side only stalls when a result is held at the output.
    `PRAC_ASSERT_IMPL(a_stall_cause, clk, rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled with output free")

    // A transaction handed to the first iteration shows up in its register.
    `PRAC_ASSERT_NEXT(a_stage_load, clk, rst_n, valid_c[0] && ready_c[0],
        valid_c[1], "first CORDIC stage dropped a transaction")

endmodule

[tb/sv/point_rotation_about_center_unit_checker.sv]
// Checker for the point rotation unit: watches both stream channels, predicts each result.
// Depends on prac_pkg for the angle width; reports a mismatch count and a pending count.
`timescale 1ns / 1ps

module point_rotation_about_center_unit_checker
    import prac_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // point_x, point_y, pivot_x, pivot_y, turn_angle, zero fill to whole bytes
    input  logic [((4*COORD_WIDTH+ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // rotated_x, rotated_y, zero fill to whole bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // clipped
    input  logic                m_axis_tuser,
    output int                  mismatch_count,
    output int                  pending_count
);

    localparam int     GUARD        = 8;
    localparam longint ROUND_HALF   = 64'sd1 <<< (GUARD - 1);
    localparam int     FOLD_LIMIT   = 16384;
    localparam int     HALF_TURN    = 32768;
    localparam longint ANGLE_SCALE  = 65536;
    localparam int     STAGE_CAP    = 24;
    localparam int     RUN_STAGES   = (CORDIC_STAGES < STAGE_CAP) ? CORDIC_STAGES : STAGE_CAP;
    localparam logic [63:0] GAIN_COMP = 64'd2608131496;
    localparam longint COORD_HI     = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO     = -COORD_HI - 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t rotated_x;
        coord_t rotated_y;
        logic   clipped;
    } rotation_t;

    // Arctangent of 2^-i in units of 2^-32 turn, truncated.
    longint atan_steps [STAGE_CAP] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
        64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    rotation_t expected_rotations [$];
    int        errors = 0;

    // Scales the offset magnitude by the CORDIC gain compensation, keeping the guard
    // bits and rounding half up, then restores the sign.
    function automatic longint compensate_gain(longint offset);
        logic [127:0] product;
        logic [63:0]  magnitude;
        longint       scaled;
        magnitude = (offset < 0) ? -offset : offset;
        product   = 128'(magnitude) * 128'(GAIN_COMP);
        scaled    = longint'(product >> (32 - GUARD)) + longint'(product[31 - GUARD]);
        return (offset < 0) ? -scaled : scaled;
    endfunction

    function automatic longint clamp_coord(longint value, ref logic clip);
        if (value > COORD_HI)
        begin
            clip = 1'b1;
            return COORD_HI;
        end
        if (value < COORD_LO)
        begin
            clip = 1'b1;
            return COORD_LO;
        end
        return value;
    endfunction

    function automatic rotation_t rotate_about_pivot(coord_t point_x, coord_t point_y,
                                                     coord_t pivot_x, coord_t pivot_y,
                                                     logic signed [ANGLE_W-1:0] turn);
        rotation_t result;
        longint    x, y, z, x_shift, y_shift, out_x, out_y;
        int        angle;
        logic      clip;
        clip  = 1'b0;
        angle = int'(turn);
        x = compensate_gain(longint'(point_x) - longint'(pivot_x));
        y = compensate_gain(longint'(point_y) - longint'(pivot_y));
        // Angles beyond a quarter turn are folded by a half turn with the vector negated.
        if (angle > FOLD_LIMIT)
        begin
            angle -= HALF_TURN;
            x = -x;
            y = -y;
        end
        else if (angle < -FOLD_LIMIT)
        begin
            angle += HALF_TURN;
            x = -x;
            y = -y;
        end
        z = longint'(angle) * ANGLE_SCALE;
        for (int i = 0; i < RUN_STAGES; i++)
        begin
            x_shift = x >>> i;
            y_shift = y >>> i;
            if (z >= 0)
            begin
                x = x - y_shift;
                y = y + x_shift;
                z = z - atan_steps[i];
            end
            else
            begin
                x = x + y_shift;
                y = y - x_shift;
                z = z + atan_steps[i];
            end
        end
        out_x = ((x + ROUND_HALF) >>> GUARD) + longint'(pivot_x);
        out_y = ((y + ROUND_HALF) >>> GUARD) + longint'(pivot_y);
        result.rotated_x = coord_t'(clamp_coord(out_x, clip));
        result.rotated_y = coord_t'(clamp_coord(out_y, clip));
        result.clipped   = clip;
        return result;
    endfunction

    task automatic report_mismatch(string field, logic signed [63:0] want,
                                   logic signed [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : watch
        rotation_t seen;
        rotation_t due;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rotations.push_back(rotate_about_pivot(
                    s_axis_tdata[COORD_WIDTH-1:0],
                    s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH],
                    s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH],
                    s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH],
                    s_axis_tdata[4*COORD_WIDTH+ANGLE_W-1:4*COORD_WIDTH]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.rotated_x = m_axis_tdata[COORD_WIDTH-1:0];
                seen.rotated_y = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                seen.clipped   = m_axis_tuser;
                if (expected_rotations.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual x %0d y %0d",
                             $time, seen.rotated_x, seen.rotated_y);
                end
                else
                begin
                    due = expected_rotations.pop_front();
                    if (seen.rotated_x !== due.rotated_x)
                        report_mismatch("rotated_x", due.rotated_x, seen.rotated_x);
                    if (seen.rotated_y !== due.rotated_y)
                        report_mismatch("rotated_y", due.rotated_y, seen.rotated_y);
                    if (seen.clipped !== due.clipped)
                        report_mismatch("clipped", due.clipped, seen.clipped);
                end
            end
            mismatch_count <= errors;
            pending_count  <= expected_rotations.size();
        end
    end

endmodule

[tb/sv/point_rotation_about_center_unit_test.sv]
// Top of the point rotation testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on prac_pkg, the point rotation unit and its checker module.
`timescale 1ns / 1ps

module point_rotation_about_center_unit_test;

    import prac_pkg::*;

    localparam int CORDIC_STAGES   = 16;
    localparam int COORD_WIDTH     = 32;
    localparam int IN_W            = ((4*COORD_WIDTH+ANGLE_W+7)/8)*8;
    localparam int OUT_W           = ((2*COORD_WIDTH+7)/8)*8;
    localparam int RANDOM_ITEMS    = 1530;
    // The block holds about CORDIC_STAGES + 7 transactions in flight.
    localparam int DRAIN_CYCLES    = CORDIC_STAGES + 7 + 20;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PRESSURE_AT     = 600;
    localparam int PRESSURE_CYCLES = 400;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0]     angle_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam coord_t UNIT      = 32'sh0001_0000;
    localparam angle_t QUARTER   = 16'sd16384;
    localparam angle_t ANGLE_MAX = 16'sh7FFF;
    localparam angle_t ANGLE_MIN = 16'sh8000;

    // One input transaction: a point, a pivot and a binary angle.
    typedef struct {
        coord_t point_x;
        coord_t point_y;
        coord_t pivot_x;
        coord_t pivot_y;
        angle_t turn_angle;
    } point_job_t;

    // Back-pressure styles of the result receiver.
    typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_e;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    int mismatch_count;
    int pending_count;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    point_rotation_about_center_unit #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The checker sees exactly the signals the block sees and keeps its own
    // queue of predicted rotations.
    point_rotation_about_center_unit_checker #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL point_rotation_about_center_unit");
        $finish;
    end

    function automatic point_job_t make_job(coord_t px, coord_t py, coord_t cx, coord_t cy,
                                            angle_t turn);
        point_job_t job;
        job.point_x    = px;
        job.point_y    = py;
        job.pivot_x    = cx;
        job.pivot_y    = cy;
        job.turn_angle = turn;
        return job;
    endfunction

    // Half the angles are uniform; the rest lie at or next to the fold boundaries at
    // a quarter turn, at the ends of the range or near zero.
    function automatic angle_t pick_angle();
        case ($urandom_range(0, 5))
            0: return QUARTER + angle_t'($urandom_range(0, 2)) - 16'sd1;
            1: return -QUARTER + angle_t'($urandom_range(0, 2)) - 16'sd1;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return ANGLE_MAX;
                    1: return ANGLE_MIN;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            default: return angle_t'($urandom);
        endcase
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return -32'sd1;
            4: return UNIT;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic point_job_t random_job();
        point_job_t job;
        int         kind;
        int         off_x;
        int         off_y;
        kind           = $urandom_range(0, 99);
        job.turn_angle = pick_angle();
        if (kind < 30)
        begin
            // Anything the fields allow, including huge offsets.
            job.point_x = coord_t'($urandom);
            job.point_y = coord_t'($urandom);
            job.pivot_x = coord_t'($urandom);
            job.pivot_y = coord_t'($urandom);
        end
        else if (kind < 70)
        begin
            // Typical geometry: a point a short distance from a moderate pivot.
            off_x       = int'($urandom_range(0, 2097152)) - 1048576;
            off_y       = int'($urandom_range(0, 2097152)) - 1048576;
            job.pivot_x = $signed($urandom) >>> 8;
            job.pivot_y = $signed($urandom) >>> 8;
            job.point_x = job.pivot_x + coord_t'(off_x);
            job.point_y = job.pivot_y + coord_t'(off_y);
        end
        else if (kind < 85)
        begin
            job.point_x = pick_coord();
            job.point_y = pick_coord();
            job.pivot_x = pick_coord();
            job.pivot_y = pick_coord();
        end
        else if (kind < 90)
        begin
            // Point on the pivot: the offset is zero whatever the angle.
            job.pivot_x = pick_coord();
            job.pivot_y = pick_coord();
            job.point_x = job.pivot_x;
            job.point_y = job.pivot_y;
        end
        else
        begin
            // Pivot and point at opposite ends of the range, which drives the
            // rotated point toward saturation.
            job.pivot_x = COORD_MAX - coord_t'($urandom_range(0, 65535));
            job.point_x = COORD_MIN + coord_t'($urandom_range(0, 65535));
            job.pivot_y = COORD_MIN + coord_t'($urandom_range(0, 65535));
            job.point_y = COORD_MAX - coord_t'($urandom_range(0, 65535));
            if ($urandom_range(0, 1))
            begin
                job.pivot_x = ~job.pivot_x;
                job.point_x = ~job.point_x;
            end
            if ($urandom_range(0, 1))
            begin
                job.pivot_y = ~job.pivot_y;
                job.point_y = ~job.point_y;
            end
        end
        return job;
    endfunction

    // Offers one transaction and holds it until the block accepts it. The
    // sender runs in bursts; between bursts tvalid usually drops for a random gap.
    task automatic send_job(point_job_t job);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({job.turn_angle, job.pivot_y, job.pivot_x,
                                job.point_y, job.point_x});
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        items_sent <= items_sent + 1;
    endtask

    // Result receiver. It cycles through back-pressure styles of random length,
    // and once, after enough transactions have gone in, it holds off for a long
    // stretch so that the pipeline fills and the block stalls its input.
    initial
    begin
        rx_mode_e   mode;
        int         mode_left;
        int         hold_left;
        int         phase;
        logic [7:0] stall_pattern;
        bit         pressure_done;
        mode          = RX_STREAM;
        mode_left     = 0;
        hold_left     = 0;
        phase         = 0;
        stall_pattern = 8'hFF;
        pressure_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!pressure_done && items_sent >= PRESSURE_AT)
            begin
                hold_left     = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode          = rx_mode_e'($urandom_range(0, 3));
                    mode_left     = $urandom_range(20, 200);
                    stall_pattern = 8'($urandom) | 8'h01;
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_STREAM:  m_axis_tready <= 1'b1;
                    RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:    m_axis_tready <= stall_pattern[phase % 8];
                endcase
            end
        end
    end

    // Stimulus: reset, a directed set of corner cases, then random traffic.
    initial
    begin
        point_job_t directed [$];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero everywhere, then unit points around the fold boundaries, at the angle extremes and about a unit pivot.
        directed.push_back(make_job('0, '0, '0, '0, 16'sd0));
        directed.push_back(make_job(UNIT, '0, '0, '0, QUARTER));
        directed.push_back(make_job(UNIT, '0, '0, '0, -QUARTER));
        directed.push_back(make_job(UNIT, UNIT, '0, '0, QUARTER + 16'sd1));
        directed.push_back(make_job(UNIT, UNIT, '0, '0, -QUARTER - 16'sd1));
        directed.push_back(make_job(UNIT, -UNIT, '0, '0, QUARTER - 16'sd1));
        directed.push_back(make_job(-UNIT, UNIT, '0, '0, -QUARTER + 16'sd1));
        directed.push_back(make_job(UNIT, '0, '0, '0, ANGLE_MAX));
        directed.push_back(make_job(UNIT, '0, '0, '0, ANGLE_MIN));
        directed.push_back(make_job(UNIT, '0, UNIT, UNIT, 16'sd8192));
        // Largest offsets, with and without saturation.
        directed.push_back(make_job(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'sd0));
        directed.push_back(make_job(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, ANGLE_MIN));
        directed.push_back(make_job(COORD_MAX, COORD_MIN, '0, '0, QUARTER));
        directed.push_back(make_job(COORD_MIN, COORD_MAX, '0, '0, -QUARTER));
        directed.push_back(make_job(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, ANGLE_MAX));
        directed.push_back(make_job(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 16'sd1));
        // Point on the pivot, sign flips around zero and alternating bit patterns.
        directed.push_back(make_job(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'sd12345));
        directed.push_back(make_job(-32'sd1, -32'sd1, 32'sd1, 32'sd1, 16'sd1));
        directed.push_back(make_job(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -16'sd1));
        directed.push_back(make_job('0, '0, COORD_MIN, COORD_MAX, QUARTER - 16'sd1));
        directed.push_back(make_job(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                                    32'sh5555_5555, 16'sh5555));
        directed.push_back(make_job(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                                    32'shAAAA_AAAA, 16'shAAAA));

        foreach (directed[i])
            send_job(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_job(random_job());
        s_axis_tvalid <= 1'b0;

        // The wait below lets the checker count the final transaction before the
        // pending count is read.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS point_rotation_about_center_unit");
        else
            $display("FAIL point_rotation_about_center_unit");
        $finish;
    end

endmodule
